### rtl/dasmg_pkg.sv
// package for the two-axis step/direction move generator: item types and constants
`default_nettype none

package dasmg_pkg;

    // widths of the item fields
    localparam int unsigned TARGET_W = 24;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned PRESC_W  = 8;

    // default and limits of the stored position width
    localparam int unsigned POS_WIDTH_DEF = 24;
    localparam int unsigned POS_WIDTH_MAX = 32;

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_ZERO = 2'd2;

    // reset value of the prescaler register and countdown
    localparam logic [PRESC_W-1:0] PRESC_RST = 8'd2;

    // divide by 200 with rounding: (mag + 100) / 8 / 25, saturated
    localparam int unsigned WIDE_W      = POS_WIDTH_MAX + 2;
    localparam int unsigned HALF_DIV    = 100;
    localparam int unsigned SAT_LIMIT   = 52428800;  // 262144 * 200
    localparam int unsigned RECIP25     = 10737419;  // ceil(2^28 / 25)
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned QUOT_W      = 18;
    localparam int unsigned DIVIN_W     = 23;
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned PROD_W      = DIVIN_W + RECIP_W;
    localparam logic [QUOT_W:0] COUNT_MAX = 19'd524286;

    // input item
    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [TARGET_W-1:0] target_x;
        logic signed [TARGET_W-1:0] target_y;
    } t_in_item;

    // result item
    typedef struct packed {
        logic step_x;
        logic dir_x;
        logic step_y;
        logic dir_y;
        logic busy_res;
        logic rejected;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/dual_axis_stepper_move_generator.sv
// top level of the two-axis step/direction move generator
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_item (t_in_item)
//   out     | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//   cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_data (tick_prescale)
//
// one item per cycle while o_in_stall is low: each item is decoded in the cycle it is
// accepted, and its new state and its result land in their registers at the same clock edge
// the longest path is the position subtract, rounding add and reciprocal multiply
// i_rst_n is synchronous active low and clears position, counts, pins and busy
// o_in_stall rises only while a result is held in the output register and the
// output side stalls; otherwise an item is taken while the old result drains
`default_nettype none

module dual_axis_stepper_move_generator #(
    parameter int unsigned POS_WIDTH = dasmg_pkg::POS_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire dasmg_pkg::t_in_item           i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output dasmg_pkg::t_out_item               o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dasmg_pkg::PRESC_W-1:0] i_cfg_data
);
    import dasmg_pkg::*;

    localparam int unsigned DIFF_W = POS_WIDTH + 1;

    // configuration and state registers
    logic [PRESC_W-1:0]        r_presc;
    logic [PRESC_W-1:0]        r_pcount, n_pcount;
    logic signed [POS_WIDTH-1:0] r_last_x, n_last_x;
    logic signed [POS_WIDTH-1:0] r_last_y, n_last_y;
    logic signed [COUNT_W-1:0] r_rem_x, n_rem_x;
    logic signed [COUNT_W-1:0] r_rem_y, n_rem_y;
    logic                      r_act_x, n_act_x;
    logic                      r_act_y, n_act_y;
    logic                      r_busy, n_busy;
    logic                      r_step_x, n_step_x;
    logic                      r_dir_x, n_dir_x;
    logic                      r_step_y, n_step_y;
    logic                      r_dir_y, n_dir_y;
    logic                      n_rej;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    logic                      in_take;
    logic [POS_WIDTH_MAX-1:0]  ext_x, ext_y;
    logic signed [POS_WIDTH-1:0] tgt_x, tgt_y;
    logic signed [DIFF_W-1:0]  diff_x, diff_y;
    logic [PRESC_W-1:0]        pc_dec;

    // signed toggle count for a position difference: round(|d| / 200) * 2
    function automatic logic signed [COUNT_W-1:0] toggles_for(
        input logic signed [DIFF_W-1:0] d
    );
        logic [DIFF_W-1:0]  mag;
        logic [WIDE_W-1:0]  m;
        logic [DIVIN_W-1:0] x;
        logic [PROD_W-1:0]  prod;
        logic [QUOT_W:0]    cnt;
        mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        m   = WIDE_W'(mag) + WIDE_W'(HALF_DIV);
        x   = m[DIVIN_W+2:3];
        prod = PROD_W'(x) * PROD_W'(RECIP25);
        if (m >= WIDE_W'(SAT_LIMIT)) begin
            cnt = COUNT_MAX;
        end else begin
            cnt = {prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT], 1'b0};
        end
        return d[DIFF_W-1] ? -COUNT_W'(cnt) : COUNT_W'(cnt);
    endfunction

    // handshakes
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_take     = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // targets: sign-extend the field, then wrap to the position width
    assign ext_x  = {{(POS_WIDTH_MAX-TARGET_W){i_in_item.target_x[TARGET_W-1]}},
                     i_in_item.target_x};
    assign ext_y  = {{(POS_WIDTH_MAX-TARGET_W){i_in_item.target_y[TARGET_W-1]}},
                     i_in_item.target_y};
    assign tgt_x  = ext_x[POS_WIDTH-1:0];
    assign tgt_y  = ext_y[POS_WIDTH-1:0];
    assign diff_x = {tgt_x[POS_WIDTH-1], tgt_x} - {r_last_x[POS_WIDTH-1], r_last_x};
    assign diff_y = {tgt_y[POS_WIDTH-1], tgt_y} - {r_last_y[POS_WIDTH-1], r_last_y};
    assign pc_dec = r_pcount - PRESC_W'(1);

    // next state for the accepted item
    always_comb begin
        n_pcount = r_pcount;
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        n_rem_x  = r_rem_x;
        n_rem_y  = r_rem_y;
        n_act_x  = r_act_x;
        n_act_y  = r_act_y;
        n_busy   = r_busy;
        n_step_x = r_step_x;
        n_dir_x  = r_dir_x;
        n_step_y = r_step_y;
        n_dir_y  = r_dir_y;
        n_rej    = 1'b0;
        case (i_in_item.req_type)
            REQ_MOVE: begin
                if (r_busy) begin
                    n_rej = 1'b1;
                end else begin
                    n_rem_x  = toggles_for(diff_x);
                    n_rem_y  = toggles_for(diff_y);
                    n_last_x = tgt_x;
                    n_last_y = tgt_y;
                    n_act_x  = 1'b1;
                    n_act_y  = 1'b1;
                    n_busy   = 1'b1;
                    n_pcount = r_presc;
                end
            end
            REQ_ZERO: begin
                n_last_x = '0;
                n_last_y = '0;
            end
            REQ_TICK: begin
                if (r_busy) begin
                    n_pcount = pc_dec;
                    if (pc_dec == '0) begin
                        n_pcount = r_presc;
                        // x axis step, direction high when positive
                        if (r_rem_x == '0) begin
                            n_act_x = 1'b0;
                        end else begin
                            n_dir_x  = ~r_rem_x[COUNT_W-1];
                            n_step_x = ~r_step_x;
                            n_rem_x  = r_rem_x[COUNT_W-1] ? r_rem_x + COUNT_W'(1)
                                                          : r_rem_x - COUNT_W'(1);
                        end
                        // y axis step, direction inverted
                        if (r_rem_y == '0) begin
                            n_act_y = 1'b0;
                        end else begin
                            n_dir_y  = r_rem_y[COUNT_W-1];
                            n_step_y = ~r_step_y;
                            n_rem_y  = r_rem_y[COUNT_W-1] ? r_rem_y + COUNT_W'(1)
                                                          : r_rem_y - COUNT_W'(1);
                        end
                        if (!n_act_x && !n_act_y) begin
                            n_busy = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_rej = 1'b0;
            end
        endcase
    end

    // state, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc     <= PRESC_RST;
            r_pcount    <= PRESC_RST;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_rem_x     <= '0;
            r_rem_y     <= '0;
            r_act_x     <= 1'b0;
            r_act_y     <= 1'b0;
            r_busy      <= 1'b0;
            r_step_x    <= 1'b0;
            r_dir_x     <= 1'b0;
            r_step_y    <= 1'b0;
            r_dir_y     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_presc <= i_cfg_data;
            end
            if (in_take) begin
                r_pcount    <= n_pcount;
                r_last_x    <= n_last_x;
                r_last_y    <= n_last_y;
                r_rem_x     <= n_rem_x;
                r_rem_y     <= n_rem_y;
                r_act_x     <= n_act_x;
                r_act_y     <= n_act_y;
                r_busy      <= n_busy;
                r_step_x    <= n_step_x;
                r_dir_x     <= n_dir_x;
                r_step_y    <= n_step_y;
                r_dir_y     <= n_dir_y;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only when an item is taken
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_item.step_x   <= n_step_x;
            r_out_item.dir_x    <= n_dir_x;
            r_out_item.step_y   <= n_step_y;
            r_out_item.dir_y    <= n_dir_y;
            r_out_item.busy_res <= n_busy;
            r_out_item.rejected <= n_rej;
        end
    end

endmodule

`default_nettype wire

### rtl/dasmg_checker.sv
// port-level checks for the two-axis move generator, bound to the top level
`default_nettype none

module dasmg_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire dasmg_pkg::t_out_item o_out_item
);
    import dasmg_pkg::*;

    // a rejected move can only come while a move is still running
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rejected) |-> o_out_item.busy_res)
        else $error("rejected item without busy");

    // every accepted item shows up as a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    // a taken result with no new item leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !(i_in_valid && !o_in_stall)) |=> !o_out_valid)
        else $error("result repeated");

    // held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // output is empty after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind dual_axis_stepper_move_generator dasmg_checker u_dasmg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
